// File: src/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// property holds at every rising clock edge outside reset
`define ASSERT_PROP(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// condition never true outside reset
`define ASSERT_NEVER(name, clk, rst, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(name, clk, rst, prop, msg)
`define ASSERT_NEVER(name, clk, rst, cond, msg)
`endif

`endif

// File: src/stpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package stpc_pkg;

  localparam int ANGLE_W   = 32;
  localparam int CURRENT_W = 10;
  localparam int REF_W     = 9;
  localparam int BRIDGE_W  = 2;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // full-scale current, also the request clamp
  localparam logic [CURRENT_W-1:0] MA_FULL_SCALE = 10'd1000;

  // bridge drive codes
  localparam logic [BRIDGE_W-1:0] BRIDGE_FIRST  = 2'd0;
  localparam logic [BRIDGE_W-1:0] BRIDGE_SECOND = 2'd1;
  localparam logic [BRIDGE_W-1:0] BRIDGE_OFF    = 2'd2;

  // register index, taken from paddr[2]
  localparam logic REG_DRIVE_ENABLED    = 1'b0;
  localparam logic REG_FORWARD_ROTATION = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } wrap_status_t;

endpackage

`default_nettype wire

// File: src/stpc_mul.sv
`timescale 1ns / 1ps
`default_nettype none

module stpc_mul #(
  parameter int W = 26
) (
  input  logic           clk,
  input  logic [W-1:0]   a,
  input  logic [W-1:0]   b,
  output logic [2*W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= (2*W)'(a) * (2*W)'(b);
  end

endmodule

`default_nettype wire

// File: src/stpc_sine_rom.sv
`timescale 1ns / 1ps
`default_nettype none

module stpc_sine_rom #(
  parameter int STEPS = 1024,
  parameter int PEAK  = 32767,
  localparam int AW = $clog2(STEPS),
  localparam int EW = $clog2(PEAK + 1) + 1
) (
  input  logic                 clk,
  input  logic [AW-1:0]        addr,
  output logic signed [EW-1:0] q
);

  typedef logic signed [EW-1:0] rom_t [STEPS];

  localparam real HALF_PI  = 1.57079632679489661923;
  localparam real STEP_RAD = HALF_PI / real'(STEPS);

  // quadrant fold on 4*a, then round half away from zero
  function automatic rom_t build_rom();
    rom_t t;
    int   n;
    int   m;
    int   mag;
    bit   neg;
    real  v;
    for (int a = 0; a < STEPS; a++) begin
      n = 4 * a;
      neg = 1'b0;
      if (n <= STEPS) begin
        m = n;
      end else if (n <= 2 * STEPS) begin
        m = 2 * STEPS - n;
      end else if (n <= 3 * STEPS) begin
        m = n - 2 * STEPS;
        neg = 1'b1;
      end else begin
        m = 4 * STEPS - n;
        neg = 1'b1;
      end
      v = real'(PEAK) * $sin(STEP_RAD * real'(m));
      mag = $rtoi($floor(v + 0.5 + 1.0e-7));
      t[a] = neg ? -EW'(mag) : EW'(mag);
    end
    return t;
  endfunction

  localparam rom_t ROM_DATA = build_rom();

  always_ff @(posedge clk) begin
    q <= ROM_DATA[addr];
  end

endmodule

`default_nettype wire

// File: src/stpc_angle_wrap.sv
`timescale 1ns / 1ps
`default_nettype none

module stpc_angle_wrap #(
  parameter int STEPS = 1024,
  localparam int AW = $clog2(STEPS)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [stpc_pkg::ANGLE_W-1:0]    raw,
  output logic [AW-1:0]                   angle,
  output stpc_pkg::wrap_status_t          status
);

  import stpc_pkg::*;

  localparam int NIB = ANGLE_W / 4;
  localparam int CW  = $clog2(NIB);
  localparam int TW  = AW + 4;
  // 2^32 mod STEPS, the offset that a set sign bit adds
  localparam int unsigned K = int'((64'd1 << ANGLE_W) % STEPS);

  logic [CW-1:0]      cnt;
  logic [ANGLE_W-1:0] sh;
  logic [AW-1:0]      rem;
  logic               sign;
  logic [TW-1:0]      t;
  logic [AW:0]        adj;

  // one nibble a cycle: (rem*16 + nibble) mod STEPS by four compare-subtracts
  always_comb begin
    t = {rem, sh[ANGLE_W-1 -: 4]};
    for (int i = 3; i >= 0; i--) begin
      if (t >= TW'(STEPS << i)) begin
        t = t - TW'(STEPS << i);
      end
    end
  end

  // floor modulo of the signed angle
  always_comb begin
    if (!sign) begin
      adj = {1'b0, rem};
    end else if ({1'b0, rem} >= (AW+1)'(K)) begin
      adj = {1'b0, rem} - (AW+1)'(K);
    end else begin
      adj = {1'b0, rem} + (AW+1)'(STEPS - int'(K));
    end
  end

  assign angle = adj[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      status.busy <= 1'b0;
      status.done <= 1'b0;
      cnt <= '0;
    end else begin
      status.done <= 1'b0;
      if (start) begin
        status.busy <= 1'b1;
        cnt <= '0;
      end else if (status.busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(NIB - 1)) begin
          status.busy <= 1'b0;
          status.done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh   <= raw;
      rem  <= '0;
      sign <= raw[ANGLE_W-1];
    end else if (status.busy) begin
      sh  <= sh << 4;
      rem <= t[AW-1:0];
    end
  end

endmodule

`default_nettype wire

// File: src/stepper_microstep_phase_current.sv
// Microstep phase-current drive.
// Input channel (in_valid/in_ready) carries one beat: a signed step_angle in
// table steps and current_ma. Output channel (out_valid/out_ready) returns one
// beat per input: the angle wrapped into one electrical cycle, the sine and
// cosine coil references and both H-bridge drive codes. With the drive
// disabled the raw angle, zero references and both bridges off come back, and
// the item goes straight to the output register. With the drive enabled an
// item runs through the nibble-serial angle wrap, the two sine table reads on
// the single ROM port, the two phases that go through the one shared
// multiplier (current scaling and both constant divisions are products with a
// reciprocal and a correction) and the load of the output register. No new
// item is taken until the last one has gone into the output register.
// in_ready is high only while the sequencer idles; the finished beat sits in
// the output register, so the next item is taken while it waits.
// If the receiver stalls, the block holds the result and waits in its last
// step until the output register frees up.
// Reset sets drive_enabled and forward_rotation to 1, both bridges off, and
// drops out_valid. Configuration is written over the APB port at byte
// addresses 0 and 4; pready is always high.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module stepper_microstep_phase_current #(
  parameter int TABLE_STEPS    = 1024,
  parameter int TABLE_PEAK     = 32767,
  parameter int REF_FULL_SCALE = 511
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [stpc_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [stpc_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [stpc_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [stpc_pkg::ANGLE_W-1:0] step_angle,
  input  logic [stpc_pkg::CURRENT_W-1:0]      current_ma,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [stpc_pkg::ANGLE_W-1:0] wrapped_angle,
  output logic [stpc_pkg::REF_W-1:0]          ref_a,
  output logic [stpc_pkg::REF_W-1:0]          ref_b,
  output logic [stpc_pkg::BRIDGE_W-1:0]       bridge_a_drive,
  output logic [stpc_pkg::BRIDGE_W-1:0]       bridge_b_drive
);

  import stpc_pkg::*;

  localparam int AW   = $clog2(TABLE_STEPS);
  localparam int PW   = $clog2(TABLE_PEAK + 1);
  localparam int EW   = PW + 1;
  localparam int P_W  = CURRENT_W + PW;
  localparam int FW   = $clog2(REF_FULL_SCALE + 1);
  localparam int W_W  = CURRENT_W + FW;
  localparam int MW   = (P_W > W_W) ? P_W : W_W;
  localparam int SH1  = P_W;
  localparam int SH2  = W_W;
  localparam longint unsigned R1 = (64'd1 << SH1) / TABLE_PEAK;
  localparam longint unsigned R2 = (64'd1 << SH2) / 1000;
  localparam int QUARTER = TABLE_STEPS / 4;

  typedef enum logic [13:0] {
    S_IDLE    = 14'b00000000000001,
    S_WRAP    = 14'b00000000000010,
    S_RD_SIN  = 14'b00000000000100,
    S_RD_COS  = 14'b00000000001000,
    S_CAP_COS = 14'b00000000010000,
    S_M1      = 14'b00000000100000,
    S_M2      = 14'b00000001000000,
    S_M3      = 14'b00000010000000,
    S_M4      = 14'b00000100000000,
    S_M5      = 14'b00001000000000,
    S_M6      = 14'b00010000000000,
    S_M7      = 14'b00100000000000,
    S_M8      = 14'b01000000000000,
    S_FINISH  = 14'b10000000000000
  } state_t;

  state_t state, state_next;

  logic drive_enabled;
  logic forward_rotation;
  logic [BRIDGE_W-1:0] bridge_a_level, bridge_b_level;
  logic [BRIDGE_W-1:0] bridge_a_level_next, bridge_b_level_next;
  logic phase;

  logic [ANGLE_W-1:0]   raw_r;
  logic [CURRENT_W-1:0] ma_r;
  logic                 dis_r;
  logic [AW-1:0]        a_r;
  logic [PW-1:0]        sin_mag, cos_mag;
  logic                 sa_pos, sa_neg, cb_pos, cb_neg;
  logic [P_W-1:0]       p_r;
  logic [MW-1:0]        q_r;
  logic [CURRENT_W-1:0] amp_r;
  logic [W_W-1:0]       w_r;
  logic [REF_W-1:0]     ref_a_r, ref_b_r;

  logic                 accept, load, cfg_write;
  logic [CURRENT_W-1:0] ma_clamped;
  logic [AW-1:0]        wrap_angle;
  wrap_status_t         wst;
  logic [AW-1:0]        rom_addr;
  logic signed [EW-1:0] rom_q;
  logic [AW:0]          cos_sum;
  logic [AW-1:0]        cos_idx;
  logic [MW-1:0]        mul_a, mul_b;
  logic [2*MW-1:0]      prod;
  logic [PW-1:0]        mag;
  logic [P_W-1:0]       rem1;
  logic [W_W-1:0]       rem2;
  logic [REF_W-1:0]     ref_res;
  logic                 rom_pos, rom_neg;

  assign pready    = 1'b1;
  assign in_ready  = (state == S_IDLE) && !rst;
  assign accept    = in_valid && in_ready;
  assign load      = (state == S_FINISH) && (!out_valid || out_ready);
  assign cfg_write = psel && penable && pwrite && pready;
  assign ma_clamped = (current_ma > MA_FULL_SCALE) ? MA_FULL_SCALE : current_ma;

  assign bridge_a_drive = bridge_a_level;
  assign bridge_b_drive = bridge_b_level;

  always_comb begin
    unique case (paddr[2])
      REG_DRIVE_ENABLED:    prdata = {{(CFG_DATA_W-1){1'b0}}, drive_enabled};
      REG_FORWARD_ROTATION: prdata = {{(CFG_DATA_W-1){1'b0}}, forward_rotation};
      default:              prdata = '0;
    endcase
  end

  stpc_angle_wrap #(.STEPS(TABLE_STEPS)) u_wrap (
    .clk    (clk),
    .rst    (rst),
    .start  (accept && drive_enabled),
    .raw    (step_angle),
    .angle  (wrap_angle),
    .status (wst)
  );

  assign cos_sum = {1'b0, a_r} + (AW+1)'(QUARTER);
  assign cos_idx = (cos_sum >= (AW+1)'(TABLE_STEPS)) ?
                   AW'(cos_sum - (AW+1)'(TABLE_STEPS)) : AW'(cos_sum);
  assign rom_addr = (state == S_RD_COS) ? cos_idx : a_r;

  stpc_sine_rom #(.STEPS(TABLE_STEPS), .PEAK(TABLE_PEAK)) u_rom (
    .clk  (clk),
    .addr (rom_addr),
    .q    (rom_q)
  );

  assign rom_neg = rom_q[EW-1];
  assign rom_pos = (rom_q != '0) && !rom_q[EW-1];
  assign mag = phase ? cos_mag : sin_mag;

  // operand select for the shared multiplier, the registered product comes back in the next cycle
  always_comb begin
    unique case (state)
      S_M1: begin
        mul_a = MW'(ma_r);
        mul_b = MW'(mag);
      end
      S_M2: begin
        mul_a = MW'(prod);
        mul_b = MW'(R1);
      end
      S_M3: begin
        mul_a = MW'(prod >> SH1);
        mul_b = MW'(TABLE_PEAK);
      end
      S_M5: begin
        mul_a = MW'(amp_r);
        mul_b = MW'(REF_FULL_SCALE);
      end
      S_M6: begin
        mul_a = MW'(prod);
        mul_b = MW'(R2);
      end
      S_M7: begin
        mul_a = MW'(prod >> SH2);
        mul_b = MW'(MA_FULL_SCALE);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  stpc_mul #(.W(MW)) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // reciprocal quotient is low by at most one, the remainder fixes it
  assign rem1 = p_r - P_W'(prod);
  assign rem2 = w_r - W_W'(prod);
  assign ref_res = REF_W'(q_r + MW'(rem2 >= W_W'(MA_FULL_SCALE)));

  always_comb begin
    if (dis_r) begin
      bridge_a_level_next = BRIDGE_OFF;
      bridge_b_level_next = BRIDGE_OFF;
    end else begin
      priority if (sa_pos) bridge_a_level_next = BRIDGE_SECOND;
      else if (sa_neg)     bridge_a_level_next = BRIDGE_FIRST;
      else                 bridge_a_level_next = bridge_a_level;
      priority if (cb_pos) bridge_b_level_next = BRIDGE_SECOND;
      else if (cb_neg)     bridge_b_level_next = BRIDGE_FIRST;
      else                 bridge_b_level_next = bridge_b_level;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (in_valid) state_next = drive_enabled ? S_WRAP : S_FINISH;
      S_WRAP:    if (wst.done) state_next = S_RD_SIN;
      S_RD_SIN:  state_next = S_RD_COS;
      S_RD_COS:  state_next = S_CAP_COS;
      S_CAP_COS: state_next = S_M1;
      S_M1:      state_next = S_M2;
      S_M2:      state_next = S_M3;
      S_M3:      state_next = S_M4;
      S_M4:      state_next = S_M5;
      S_M5:      state_next = S_M6;
      S_M6:      state_next = S_M7;
      S_M7:      state_next = S_M8;
      S_M8:      state_next = phase ? S_FINISH : S_M1;
      S_FINISH:  if (load) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      phase            <= 1'b0;
      out_valid        <= 1'b0;
      drive_enabled    <= 1'b1;
      forward_rotation <= 1'b1;
      bridge_a_level   <= BRIDGE_OFF;
      bridge_b_level   <= BRIDGE_OFF;
    end else begin
      state <= state_next;
      if (state == S_CAP_COS) begin
        phase <= 1'b0;
      end else if (state == S_M8) begin
        phase <= 1'b1;
      end
      if (load) begin
        out_valid      <= 1'b1;
        bridge_a_level <= bridge_a_level_next;
        bridge_b_level <= bridge_b_level_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_write) begin
        unique case (paddr[2])
          REG_DRIVE_ENABLED:    drive_enabled    <= pwdata[0];
          REG_FORWARD_ROTATION: forward_rotation <= pwdata[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      raw_r <= step_angle;
      ma_r  <= ma_clamped;
      dis_r <= !drive_enabled;
    end
    if (state == S_WRAP && wst.done) begin
      a_r <= wrap_angle;
    end
    if (state == S_RD_COS) begin
      sin_mag <= PW'(rom_neg ? -rom_q : rom_q);
      sa_pos  <= rom_pos;
      sa_neg  <= rom_neg;
    end
    // reverse rotation flips the cosine sign, magnitude stays
    if (state == S_CAP_COS) begin
      cos_mag <= PW'(rom_neg ? -rom_q : rom_q);
      cb_pos  <= forward_rotation ? rom_pos : rom_neg;
      cb_neg  <= forward_rotation ? rom_neg : rom_pos;
    end
    if (state == S_M2) p_r <= P_W'(prod);
    if (state == S_M3) q_r <= MW'(prod >> SH1);
    if (state == S_M4) amp_r <= CURRENT_W'(q_r + MW'(rem1 >= P_W'(TABLE_PEAK)));
    if (state == S_M6) w_r <= W_W'(prod);
    if (state == S_M7) q_r <= MW'(prod >> SH2);
    if (state == S_M8) begin
      if (phase) ref_b_r <= ref_res;
      else       ref_a_r <= ref_res;
    end
    if (load) begin
      wrapped_angle <= dis_r ? signed'(raw_r) : signed'(ANGLE_W'(a_r));
      ref_a         <= dis_r ? '0 : ref_a_r;
      ref_b         <= dis_r ? '0 : ref_b_r;
    end
  end

  `ASSERT_PROP(a_wrap_done_in_wrap, clk, rst, wst.done |-> (state == S_WRAP), "wrap done outside wait")
  `ASSERT_PROP(a_busy_after_accept, clk, rst, (in_valid && in_ready) |=> !in_ready, "ready after accept")
  `ASSERT_PROP(a_bridge_a_off_zero, clk, rst, (out_valid && bridge_a_drive == BRIDGE_OFF) |-> (ref_a == '0), "ref_a nonzero with bridge a off")
  `ASSERT_PROP(a_bridge_b_off_zero, clk, rst, (out_valid && bridge_b_drive == BRIDGE_OFF) |-> (ref_b == '0), "ref_b nonzero with bridge b off")

endmodule

`default_nettype wire

// File: tb/sv/tb_stepper_microstep_phase_current.sv
`timescale 1ns / 1ps

module tb_stepper_microstep_phase_current;
  import stpc_pkg::*;

  localparam int TABLE_STEPS    = 1024;
  localparam int TABLE_PEAK     = 32767;
  localparam int REF_FULL_SCALE = 511;
  localparam int CYCLE_LIMIT    = 400000;
  localparam real HALF_PI       = 1.57079632679489661923;

  typedef struct {
    logic [ANGLE_W-1:0]  angle;
    logic [REF_W-1:0]    ref_a;
    logic [REF_W-1:0]    ref_b;
    logic [BRIDGE_W-1:0] bridge_a;
    logic [BRIDGE_W-1:0] bridge_b;
  } coil_drive_t;

  class phase_current_scoreboard;
    coil_drive_t         pending_refs[$];
    bit                  drive_on;
    bit                  forward;
    logic [BRIDGE_W-1:0] level_a;
    logic [BRIDGE_W-1:0] level_b;
    int                  errors;

    function new();
      drive_on = 1'b1;
      forward  = 1'b1;
      level_a  = BRIDGE_OFF;
      level_b  = BRIDGE_OFF;
      errors   = 0;
    endfunction

    function void apply_register(logic idx, logic [CFG_DATA_W-1:0] value);
      if (idx == REG_DRIVE_ENABLED) drive_on = value[0];
      else forward = value[0];
    endfunction

    function int pending();
      return pending_refs.size();
    endfunction

    // quarter-wave folding keeps the zero crossings exact
    function int coil_sine(int idx);
      int  n;
      int  m;
      bit  neg;
      int  mag;
      real x;
      n   = 4 * idx;
      neg = 1'b0;
      if (n <= TABLE_STEPS) m = n;
      else if (n <= 2 * TABLE_STEPS) m = 2 * TABLE_STEPS - n;
      else if (n <= 3 * TABLE_STEPS) begin
        m   = n - 2 * TABLE_STEPS;
        neg = 1'b1;
      end else begin
        m   = 4 * TABLE_STEPS - n;
        neg = 1'b1;
      end
      x   = HALF_PI * real'(m) / real'(TABLE_STEPS);
      mag = $rtoi($floor(real'(TABLE_PEAK) * $sin(x) + 0.5));
      return neg ? -mag : mag;
    endfunction

    function logic [REF_W-1:0] coil_ref(int unsigned ma, int phase);
      longint unsigned mag;
      longint unsigned amp;
      longint unsigned scaled;
      mag    = (phase < 0) ? longint'(-phase) : longint'(phase);
      amp    = (longint'(ma) * mag) / TABLE_PEAK;
      scaled = (amp * REF_FULL_SCALE) / MA_FULL_SCALE;
      return scaled[REF_W-1:0];
    endfunction

    function coil_drive_t predict_drive(logic [ANGLE_W-1:0] angle,
                                        logic [CURRENT_W-1:0] ma);
      coil_drive_t exp_drive;
      int          wrapped;
      int          sn;
      int          cs;
      int unsigned ma_clamped;
      if (!drive_on) begin
        level_a            = BRIDGE_OFF;
        level_b            = BRIDGE_OFF;
        exp_drive.angle    = angle;
        exp_drive.ref_a    = '0;
        exp_drive.ref_b    = '0;
        exp_drive.bridge_a = BRIDGE_OFF;
        exp_drive.bridge_b = BRIDGE_OFF;
        return exp_drive;
      end
      wrapped = $signed(angle) % TABLE_STEPS;
      if (wrapped < 0) wrapped += TABLE_STEPS;
      ma_clamped = (ma > MA_FULL_SCALE) ? MA_FULL_SCALE : ma;
      sn = coil_sine(wrapped);
      cs = coil_sine((wrapped + TABLE_STEPS / 4) % TABLE_STEPS);
      if (!forward) cs = -cs;
      // a zero phase leaves its bridge where it was
      if (sn > 0) level_a = BRIDGE_SECOND;
      else if (sn < 0) level_a = BRIDGE_FIRST;
      if (cs > 0) level_b = BRIDGE_SECOND;
      else if (cs < 0) level_b = BRIDGE_FIRST;
      exp_drive.angle    = wrapped;
      exp_drive.ref_a    = coil_ref(ma_clamped, sn);
      exp_drive.ref_b    = coil_ref(ma_clamped, cs);
      exp_drive.bridge_a = level_a;
      exp_drive.bridge_b = level_b;
      return exp_drive;
    endfunction

    function void note_command(logic [ANGLE_W-1:0] angle, logic [CURRENT_W-1:0] ma);
      pending_refs.push_back(predict_drive(angle, ma));
    endfunction

    function void check_result(logic [ANGLE_W-1:0] angle, logic [REF_W-1:0] ra,
                               logic [REF_W-1:0] rb, logic [BRIDGE_W-1:0] ba,
                               logic [BRIDGE_W-1:0] bb);
      coil_drive_t exp_drive;
      if (pending_refs.size() == 0) begin
        $error("result beat with no command outstanding: angle %0d", $signed(angle));
        errors++;
        return;
      end
      exp_drive = pending_refs.pop_front();
      if (angle !== exp_drive.angle) begin
        $error("wrapped_angle: expected %0d, got %0d", $signed(exp_drive.angle),
               $signed(angle));
        errors++;
      end
      if (ra !== exp_drive.ref_a) begin
        $error("ref_a: expected %0d, got %0d", exp_drive.ref_a, ra);
        errors++;
      end
      if (rb !== exp_drive.ref_b) begin
        $error("ref_b: expected %0d, got %0d", exp_drive.ref_b, rb);
        errors++;
      end
      if (ba !== exp_drive.bridge_a) begin
        $error("bridge_a_drive: expected %0d, got %0d", exp_drive.bridge_a, ba);
        errors++;
      end
      if (bb !== exp_drive.bridge_b) begin
        $error("bridge_b_drive: expected %0d, got %0d", exp_drive.bridge_b, bb);
        errors++;
      end
    endfunction
  endclass

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0]        paddr = '0;
  logic [CFG_DATA_W-1:0]        pwdata = '0;
  logic [CFG_DATA_W-1:0]        prdata;
  logic                         pready;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic signed [ANGLE_W-1:0]    step_angle = '0;
  logic [CURRENT_W-1:0]         current_ma = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic signed [ANGLE_W-1:0]    wrapped_angle;
  logic [REF_W-1:0]             ref_a;
  logic [REF_W-1:0]             ref_b;
  logic [BRIDGE_W-1:0]          bridge_a_drive;
  logic [BRIDGE_W-1:0]          bridge_b_drive;

  phase_current_scoreboard sb;
  int in_beats = 0;
  int cycles = 0;
  int rx_idle_pct = 0;
  int rx_hold = 0;
  int tx_idle_pct = 0;

  stepper_microstep_phase_current #(
    .TABLE_STEPS(TABLE_STEPS),
    .TABLE_PEAK(TABLE_PEAK),
    .REF_FULL_SCALE(REF_FULL_SCALE)
  ) uut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .step_angle(step_angle),
    .current_ma(current_ma),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .wrapped_angle(wrapped_angle),
    .ref_a(ref_a),
    .ref_b(ref_b),
    .bridge_a_drive(bridge_a_drive),
    .bridge_b_drive(bridge_b_drive)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        sb.note_command(step_angle, current_ma);
        in_beats++;
      end
      if (out_valid && out_ready)
        sb.check_result(wrapped_angle, ref_a, ref_b, bridge_a_drive, bridge_b_drive);
    end
  end

  // receiver, with an optional long hold-off
  always @(negedge clk) begin
    if (rst) begin
      out_ready = 1'b0;
    end else if (rx_hold > 0) begin
      out_ready = 1'b0;
      rx_hold--;
    end else begin
      out_ready = ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // entered and left at a falling edge; valid stays high on exit
  task automatic send_command(input logic [ANGLE_W-1:0] angle,
                              input logic [CURRENT_W-1:0] ma);
    int target;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    step_angle = angle;
    current_ma = ma;
    target     = in_beats + 1;
    while (in_beats < target) @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (sb.pending() > 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    sb.apply_register(idx, value);
  endtask

  task automatic random_config();
    wait_drained();
    write_reg(REG_DRIVE_ENABLED, {31'($urandom), 1'($urandom_range(99) < 85)});
    write_reg(REG_FORWARD_ROTATION, {31'($urandom), 1'($urandom_range(1))});
  endtask

  task automatic send_random();
    logic [ANGLE_W-1:0]   angle;
    logic [CURRENT_W-1:0] ma;
    case ($urandom_range(4))
      0: angle = $urandom_range(6000) - 3000;
      // land on or next to a zero crossing
      1: angle = ANGLE_W'({$urandom, 10'b0} + 256 * $urandom_range(3)
                          + $urandom_range(4) - 2);
      2: angle = $urandom_range(1) ? 32'h7FFF_FFFF - $urandom_range(2047)
                                   : 32'h8000_0000 + $urandom_range(2047);
      default: angle = $urandom;
    endcase
    case ($urandom_range(5))
      0: ma = CURRENT_W'($urandom_range(990, 1023));
      1: ma = CURRENT_W'($urandom_range(15));
      default: ma = CURRENT_W'($urandom_range(1023));
    endcase
    send_command(angle, ma);
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset settings: enabled, forward; zero sine keeps bridge a off
    send_command(0, 500);
    send_command(256, 1000);
    send_command(512, 1023);
    send_command(768, 1001);
    send_command(-1, 1);
    send_command(1023, 999);
    send_command(1024, 0);
    send_command(-1024, 1000);
    send_command(32'h7FFF_FFFF, 1023);
    send_command(32'h8000_0000, 1000);
    send_command(-300, 700);

    // reverse, upper bits set
    wait_drained();
    write_reg(REG_FORWARD_ROTATION, 32'hFFFF_FFFE);
    send_command(0, 1000);
    send_command(256, 1000);
    send_command(512, 1000);
    send_command(768, 1000);
    send_command(-129, 333);

    // disabled
    wait_drained();
    write_reg(REG_DRIVE_ENABLED, 32'hFFFF_FFFE);
    send_command(-5, 1023);
    send_command(32'h8000_0000, 1000);
    send_command(32'h7FFF_FFFF, 0);

    // back on from bridges off; zero phases must hold them off
    wait_drained();
    write_reg(REG_DRIVE_ENABLED, 32'h0000_0001);
    write_reg(REG_FORWARD_ROTATION, 32'h0000_0003);
    send_command(512, 1000);
    send_command(0, 1000);

    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 18 : (phase == 1) ? 71 : 0;
      rx_idle_pct = (phase == 0) ? 71 : (phase == 1) ? 18 : 0;
      for (int blk = 0; blk < 4; blk++) begin
        random_config();
        for (int i = 0; i < 41; i++) send_random();
      end
    end

    // long receiver stall while commands keep coming
    random_config();
    write_reg(REG_DRIVE_ENABLED, 32'h1);
    rx_hold = 300;
    for (int i = 0; i < 40; i++) send_random();

    wait_drained();
    repeat (40) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
